@@ hw/rtl/hough_circle_vote_accumulator_top_defines.svh @@
// Assertion macros shared by the vote accumulator RTL.
`ifndef HOUGH_CIRCLE_VOTE_ACCUMULATOR_TOP_DEFINES_SVH
`define HOUGH_CIRCLE_VOTE_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define HCVA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define HCVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define HCVA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HCVA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/hcva_pkg.sv @@
`timescale 1ns / 1ps

package hcva_pkg;

  // Angles per vote and the angle counter width
  localparam int NUM_ANGLES = 64;
  localparam int ANGLE_W    = $clog2(NUM_ANGLES);

  // Field widths
  localparam int CELL_W     = 10;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes
  localparam logic [1:0] CMD_VOTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic [PIX_W-1:0]  radius;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] vote_count;
    logic               above_threshold;
  } rsp_t;

  // Q2.14 trig table, one 16-bit two's complement entry per angle
  typedef logic [NUM_ANGLES-1:0][15:0] trig_tab_t;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  // Taylor series on the first octant; t is a fraction of a turn scaled by 2^32
  function automatic longint unsigned oct_val(input longint unsigned t, input bit want_sin);
    longint unsigned r, r2, r3, r4, r5, r6, r7, r8, r9, r10;
    longint sv, cv, v;
    r   = (t * PI_Q30) >> 31;
    r2  = (r * r) >> 30;
    r3  = (r2 * r) >> 30;
    r4  = (r2 * r2) >> 30;
    r5  = (r4 * r) >> 30;
    r6  = (r4 * r2) >> 30;
    r7  = (r6 * r) >> 30;
    r8  = (r4 * r4) >> 30;
    r9  = (r8 * r) >> 30;
    r10 = (r8 * r2) >> 30;
    sv = longint'(r) - longint'(r3 / 6) + longint'(r5 / 120)
       - longint'(r7 / 5040) + longint'(r9 / 362880);
    cv = longint'(Q30_ONE) - longint'(r2 / 2) + longint'(r4 / 24)
       - longint'(r6 / 720) + longint'(r8 / 40320) - longint'(r10 / 3628800);
    v = want_sin ? sv : cv;
    if (v < 0) begin
      v = 0;
    end
    return longint'((v + 64'sd32768) >> 16);
  endfunction

  // Full-turn table built at elaboration by octant folding
  function automatic trig_tab_t build_trig(input bit want_sin);
    trig_tab_t tab;
    longint unsigned p, f;
    longint s, c, cs, sn;
    int q;
    int i;
    tab = '0;
    for (i = 0; i < NUM_ANGLES; i++) begin
      p = (longint'(i) << 32) / NUM_ANGLES;
      q = int'((p >> 30) & 64'd3);
      f = p & (Q30_ONE - 1);
      if (f <= (Q30_ONE >> 1)) begin
        s = longint'(oct_val(f, 1'b1));
        c = longint'(oct_val(f, 1'b0));
      end else begin
        c = longint'(oct_val(Q30_ONE - f, 1'b1));
        s = longint'(oct_val(Q30_ONE - f, 1'b0));
      end
      case (q)
        0: begin
          cs = c;
          sn = s;
        end
        1: begin
          cs = -s;
          sn = c;
        end
        2: begin
          cs = -c;
          sn = -s;
        end
        default: begin
          cs = s;
          sn = -c;
        end
      endcase
      tab[i] = want_sin ? 16'(sn) : 16'(cs);
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig(1'b1);

endpackage

@@ hw/rtl/hough_circle_vote_accumulator_top.sv @@
`timescale 1ns / 1ps
// Circle Hough vote accumulator.
// Command channel (cmd_valid/cmd_ready/cmd_data) takes one beat per command:
//   vote  - adds one to each in-range angle's cell for an in-image pixel and radius,
//   read  - returns one cell count and its threshold flag on the response
//           channel (rsp_valid/rsp_ready/rsp_data),
//   clear - zeroes the whole store; vote and clear return nothing.
// Registers are written on the cfg port (cfg_wen/cfg_idx/cfg_data); the user must
// write them only while idle, which the block does not enforce. Counts live in one
// ACC_SIDE*ACC_SIDE x 16 single-port-write memory with a registered read. Each
// vote issues one angle per cycle into a three-stage product / read /
// increment-write pipeline, with forwarding for back-to-back hits on the same cell.
// A read passes through the read and modify/write stages into the response
// register; a clear walks the memory one entry a cycle. Reset runs the same
// clearing pass before the first command beat is taken; cfg writes work throughout.
// A stalled receiver holds the response beat in its output register; the next
// command is still taken, and only a further read waits for the slot to free.
module hough_circle_vote_accumulator_top #(
  parameter int ACC_SIDE = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  hcva_pkg::cmd_t                      cmd_data,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output hcva_pkg::rsp_t                      rsp_data,
  input  logic                                cfg_wen,
  input  logic [hcva_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [hcva_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "hough_circle_vote_accumulator_top_defines.svh"

  localparam int DEPTH  = ACC_SIDE * ACC_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = hcva_pkg::CELL_W;
  localparam int MULW   = AW + CW;
  localparam int CNT_W  = hcva_pkg::COUNT_W;
  localparam int DIM_W  = hcva_pkg::DIM_W;
  localparam int ANG_W  = hcva_pkg::ANGLE_W;
  localparam bit SIDE_CAP = (ACC_SIDE >= (1 << CW));
  localparam logic [CW-1:0] SIDE_LIM = SIDE_CAP ? '1 : CW'(ACC_SIDE);
  localparam logic [ANG_W-1:0] LAST_ANGLE = ANG_W'(hcva_pkg::NUM_ANGLES - 1);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(DEPTH - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_VOTE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;

  function automatic logic in_acc(input logic [CW-1:0] c);
    return SIDE_CAP || (c < SIDE_LIM);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [MULW-1:0] full;
    full = MULW'(a) * MULW'(ACC_SIDE) + MULW'(b);
    return full[AW-1:0];
  endfunction

  // Configuration registers
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] diagonal_offset;
  logic [CNT_W-1:0] vote_threshold;

  // Sequencer and item registers
  logic [2:0]       state;
  logic [ANG_W-1:0] angle;
  logic [AW-1:0]    clear_ptr;
  logic [7:0]       rad_q;
  logic [CW-1:0]    base_x;
  logic [CW-1:0]    base_y;
  logic [CW-1:0]    rd_cell_a;
  logic [CW-1:0]    rd_cell_b;

  // Product stage
  logic               p_valid;
  logic signed [24:0] prod_c;
  logic signed [24:0] prod_s;

  // Read stage
  logic          rd_valid;
  logic          rd_read;
  logic          rd_oob;
  logic [AW-1:0] rd_addr;

  // Modify/write stage
  logic          m_valid;
  logic          m_read;
  logic          m_oob;
  logic [AW-1:0] m_addr;

  // Memory ports and last write for forwarding
  logic [CNT_W-1:0] vote_store [DEPTH];
  logic [CNT_W-1:0] mem_rd;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [CNT_W-1:0] mem_wd;
  logic             mem_re;
  logic             last_we;
  logic [AW-1:0]    last_wa;
  logic [CNT_W-1:0] last_wd;

  logic [CW-1:0]      side;
  logic signed [25:0] va;
  logic signed [25:0] vb;
  logic [CW-1:0]      ca;
  logic [CW-1:0]      cb;
  logic               a_ok;
  logic               b_ok;
  logic               fwd_hit;
  logic [CNT_W-1:0]   m_cur;
  logic               m_done;
  logic               clearing;
  logic               read_oob;

  assign cmd_ready = (state == ST_IDLE);
  assign clearing  = (state == ST_CLEAR);
  assign side      = {diagonal_offset, 1'b1};

  // Cell coordinates for the angle in the product stage
  always_comb begin
    va = $signed({2'b00, base_x, 14'd0}) - $signed({prod_c[24], prod_c});
    vb = $signed({2'b00, base_y, 14'd0}) - $signed({prod_s[24], prod_s});
    ca = va[23:14];
    cb = vb[23:14];
    a_ok = !va[25] && (ca < side) && in_acc(ca);
    b_ok = !vb[25] && (cb < side) && in_acc(cb);
  end

  assign read_oob = !((rd_cell_a < side) && (rd_cell_b < side) && in_acc(rd_cell_a) &&
                      in_acc(rd_cell_b));

  // Increment with forwarding from the write of the previous cycle
  assign fwd_hit = last_we && (last_wa == m_addr);
  assign m_cur   = fwd_hit ? last_wd : mem_rd;
  assign m_done  = m_valid && (!m_read || !rsp_valid || rsp_ready);

  assign mem_re = rd_valid && !rd_oob;
  assign mem_we = clearing || (m_valid && !m_read);
  assign mem_wa = clearing ? clear_ptr : m_addr;
  assign mem_wd = clearing ? '0 : m_cur + CNT_W'(1);

  // Vote store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vote_store[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd <= vote_store[rd_addr];
    end
  end

  // Sequencer, pipeline and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      angle           <= '0;
      clear_ptr       <= '0;
      p_valid         <= 1'b0;
      rd_valid        <= 1'b0;
      m_valid         <= 1'b0;
      rsp_valid       <= 1'b0;
      last_we         <= 1'b0;
      image_width     <= 9'd256;
      image_height    <= 9'd256;
      diagonal_offset <= 9'd363;
      vote_threshold  <= 16'd100;
    end else begin
      // Register writes
      if (cfg_wen) begin
        case (cfg_idx)
          hcva_pkg::REG_IMAGE_WIDTH:    image_width     <= cfg_data[DIM_W-1:0];
          hcva_pkg::REG_IMAGE_HEIGHT:   image_height    <= cfg_data[DIM_W-1:0];
          hcva_pkg::REG_DIAGONAL:       diagonal_offset <= cfg_data[DIM_W-1:0];
          hcva_pkg::REG_VOTE_THRESHOLD: vote_threshold  <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      // Command sequencing
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            rad_q     <= cmd_data.radius;
            base_x    <= CW'(cmd_data.pixel_x) + CW'(diagonal_offset);
            base_y    <= CW'(cmd_data.pixel_y) + CW'(diagonal_offset);
            rd_cell_a <= cmd_data.cell_a;
            rd_cell_b <= cmd_data.cell_b;
            angle     <= '0;
            case (cmd_data.command)
              hcva_pkg::CMD_VOTE: begin
                if ((DIM_W'(cmd_data.pixel_x) < image_width) &&
                    (DIM_W'(cmd_data.pixel_y) < image_height)) begin
                  state <= ST_VOTE;
                end
              end
              hcva_pkg::CMD_READ:  state <= ST_READ;
              hcva_pkg::CMD_CLEAR: state <= ST_CLEAR;
              default: ;
            endcase
          end
        end
        ST_VOTE: begin
          angle <= angle + ANG_W'(1);
          if (angle == LAST_ANGLE) begin
            state <= ST_DRAIN;
          end
        end
        ST_READ: state <= ST_DRAIN;
        ST_DRAIN: begin
          if (!p_valid && !rd_valid && !m_valid) begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          if (clear_ptr == LAST_ENTRY) begin
            clear_ptr <= '0;
            state     <= ST_IDLE;
          end else begin
            clear_ptr <= clear_ptr + AW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Product stage
      p_valid <= (state == ST_VOTE);
      prod_c  <= 25'($signed({1'b0, rad_q})) * 25'($signed(hcva_pkg::COS_TAB[angle]));
      prod_s  <= 25'($signed({1'b0, rad_q})) * 25'($signed(hcva_pkg::SIN_TAB[angle]));

      // Read stage: either a vote cell or the read command's cell
      if (state == ST_READ) begin
        rd_valid <= 1'b1;
        rd_read  <= 1'b1;
        rd_oob   <= read_oob;
        rd_addr  <= cell_addr(rd_cell_a, rd_cell_b);
      end else begin
        rd_valid <= p_valid && a_ok && b_ok;
        rd_read  <= 1'b0;
        rd_oob   <= 1'b0;
        rd_addr  <= cell_addr(ca, cb);
      end

      // Modify/write stage; a read waits here for the response slot
      if (!m_valid || m_done) begin
        m_valid <= rd_valid;
        m_read  <= rd_read;
        m_oob   <= rd_oob;
        m_addr  <= rd_addr;
      end

      last_we <= mem_we;
      last_wa <= mem_wa;
      last_wd <= mem_wd;

      // Response beat
      if (m_done && m_read) begin
        rsp_valid                <= 1'b1;
        rsp_data.vote_count      <= m_oob ? '0 : m_cur;
        rsp_data.above_threshold <= !m_oob && (m_cur >= vote_threshold);
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `HCVA_ASSERT_IMPLY(a_ready_empty, clk, rst, cmd_ready, !p_valid && !rd_valid && !m_valid)
  `HCVA_ASSERT_IMPLY(a_clear_quiet, clk, rst, state == ST_CLEAR, !rd_valid && !m_valid)
  `HCVA_ASSERT_NEXT(a_read_result, clk, rst, m_done && m_read, rsp_valid)
  `HCVA_ASSERT_IMPLY(a_ptr_idle, clk, rst, state != ST_CLEAR, clear_ptr == '0)

endmodule
